[src/keyboard_line_editor_text_console_unit_defines.svh]
// ----------------------------------------------------------------------------
// keyboard line editor assertion macros
// shared concurrent assertion forms, clocked on clk and idle during rst_n low
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_LINE_EDITOR_TEXT_CONSOLE_UNIT_DEFINES_SVH
`define KEYBOARD_LINE_EDITOR_TEXT_CONSOLE_UNIT_DEFINES_SVH

// same-cycle implication
`define KLE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KLE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/kle_pkg.sv]
// ----------------------------------------------------------------------------
// kle_pkg
// shared constants, key maps and result word layout of the line editor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kle_pkg;

    // default screen and line geometry
    localparam int COLUMNS_DEF    = 80;
    localparam int ROWS_DEF       = 25;
    localparam int LINE_STORE_DEF = 256;

    // fixed field widths
    localparam int CODE_W = 8;
    localparam int CELL_W = 11;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int LLEN_W = 8;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

    // set-1 scancodes
    localparam logic [CODE_W-1:0] KEY_BACK      = 8'h0E;
    localparam logic [CODE_W-1:0] KEY_ENTER     = 8'h1C;
    localparam logic [CODE_W-1:0] KEY_LSHIFT    = 8'h2A;
    localparam logic [CODE_W-1:0] KEY_RSHIFT    = 8'h36;
    localparam logic [CODE_W-1:0] KEY_CAPS      = 8'h3A;
    localparam logic [CODE_W-1:0] KEY_LSHIFT_UP = 8'hAA;
    localparam logic [CODE_W-1:0] KEY_RSHIFT_UP = 8'hB6;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

    // key maps cover codes below MAP_SIZE
    localparam int MAP_SIZE = 58;
    localparam int MAP_IDX_W = 6;

    localparam logic [CHAR_W-1:0] PLAIN_MAP [0:MAP_SIZE-1] = '{
        8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
        8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00, 8'h71, 8'h77, 8'h65, 8'h72,
        8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h00, 8'h00,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
        8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
        8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    localparam logic [CHAR_W-1:0] UPPER_MAP [0:MAP_SIZE-1] = '{
        8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00, 8'h51, 8'h57, 8'h45, 8'h52,
        8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h00, 8'h00,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
        8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
        8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h00, 8'h00, 8'h20
    };

    // result word; last member sits in the lowest bits
    typedef struct packed {
        logic              char_appended;
        logic [LLEN_W-1:0] line_length;
        logic              line_submit;
        logic [CELL_W-1:0] cursor_position;
        logic              cursor_changed;
        logic [ATTR_W-1:0] write_attr;
        logic [CHAR_W-1:0] write_char;
        logic [CELL_W-1:0] write_address;
        logic              write_attr_valid;
        logic              write_valid;
    } kle_result_t;

    localparam int RESULT_W   = $bits(kle_result_t);
    localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

[src/kle_step.sv]
// ----------------------------------------------------------------------------
// kle_step
// one scancode against the editor state: next state and the result word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kle_step #(
    parameter int COLUMNS    = kle_pkg::COLUMNS_DEF,
    parameter int ROWS       = kle_pkg::ROWS_DEF,
    parameter int LINE_STORE = kle_pkg::LINE_STORE_DEF,
    parameter int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
    parameter int ROW_W      = (ROWS > 1) ? $clog2(ROWS) : 1,
    parameter int LEN_W      = (LINE_STORE > 1) ? $clog2(LINE_STORE) : 1
) (
    input  logic [kle_pkg::CODE_W-1:0] scancode,
    input  logic [kle_pkg::ATTR_W-1:0] text_attribute,
    input  logic                       shift_held,
    input  logic                       caps_active,
    input  logic [COL_W-1:0]           cursor_column,
    input  logic [ROW_W-1:0]           cursor_row,
    input  logic [LEN_W-1:0]           typed_length,
    output logic                       shift_held_next,
    output logic                       caps_active_next,
    output logic [COL_W-1:0]           cursor_column_next,
    output logic [ROW_W-1:0]           cursor_row_next,
    output logic [LEN_W-1:0]           typed_length_next,
    output kle_pkg::kle_result_t       result
);
    import kle_pkg::*;

    function automatic logic [CELL_W-1:0] cell_of(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
        return CELL_W'(CELL_W'(r) * CELL_W'(COLUMNS) + CELL_W'(c));
    endfunction

    logic [CHAR_W-1:0] key_char;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [LEN_W-1:0]  len_out;

    // shifted map when exactly one of shift and caps is active
    always_comb
    begin
        if (shift_held ^ caps_active)
            key_char = UPPER_MAP[scancode[MAP_IDX_W-1:0]];
        else
            key_char = PLAIN_MAP[scancode[MAP_IDX_W-1:0]];
    end

    assign col_inc = {1'b0, cursor_column} + (COL_W+1)'(1);
    assign row_inc = {1'b0, cursor_row} + (ROW_W+1)'(1);

    always_comb
    begin
        shift_held_next    = shift_held;
        caps_active_next   = caps_active;
        cursor_column_next = cursor_column;
        cursor_row_next    = cursor_row;
        typed_length_next  = typed_length;
        len_out            = typed_length;
        result             = '0;

        unique case (scancode) inside
            KEY_LSHIFT, KEY_RSHIFT:       shift_held_next = 1'b1;
            KEY_LSHIFT_UP, KEY_RSHIFT_UP: shift_held_next = 1'b0;
            KEY_CAPS:                     caps_active_next = ~caps_active;
            KEY_ENTER:
            begin
                result.line_submit = 1'b1;
                typed_length_next  = '0;
            end
            KEY_BACK:
            begin
                if (typed_length != '0)
                begin
                    typed_length_next = typed_length - LEN_W'(1);
                    len_out           = typed_length - LEN_W'(1);
                    if (cursor_column == '0)
                    begin
                        // top-left cell stays put
                        if (cursor_row != '0)
                        begin
                            cursor_row_next    = cursor_row - ROW_W'(1);
                            cursor_column_next = COL_W'(COLUMNS - 1);
                        end
                    end
                    else
                    begin
                        cursor_column_next = cursor_column - COL_W'(1);
                    end
                    result.write_valid    = 1'b1;
                    result.write_address  = cell_of(cursor_row_next, cursor_column_next);
                    result.write_char     = CHAR_SPACE;
                    result.cursor_changed = 1'b1;
                end
            end
            default:
            begin
                if (scancode < CODE_W'(MAP_SIZE) && key_char != '0 &&
                    typed_length < LEN_W'(LINE_STORE - 1))
                begin
                    typed_length_next       = typed_length + LEN_W'(1);
                    len_out                 = typed_length + LEN_W'(1);
                    result.write_valid      = 1'b1;
                    result.write_attr_valid = 1'b1;
                    result.write_address    = cell_of(cursor_row, cursor_column);
                    result.write_char       = key_char;
                    result.write_attr       = text_attribute;
                    result.char_appended    = 1'b1;
                    result.cursor_changed   = 1'b1;
                    // wrap to next row, clamp on the last row
                    if (col_inc >= (COL_W+1)'(COLUMNS))
                    begin
                        cursor_column_next = '0;
                        if (row_inc >= (ROW_W+1)'(ROWS))
                            cursor_row_next = ROW_W'(ROWS - 1);
                        else
                            cursor_row_next = row_inc[ROW_W-1:0];
                    end
                    else
                    begin
                        cursor_column_next = col_inc[COL_W-1:0];
                    end
                end
            end
        endcase

        result.line_length     = LLEN_W'(len_out);
        result.cursor_position = cell_of(cursor_row_next, cursor_column_next);
    end

endmodule

[src/keyboard_line_editor_text_console_unit.sv]
// ----------------------------------------------------------------------------
// keyboard_line_editor_text_console_unit
// set-1 scancode line editor: shift/caps tracking, cursor and line length,
// one result word with the cursor position per scancode, holding at most one screen write
// path: the accepted scancode waits in the input register, its result word in the result register
// throughput: 1 scancode per cycle while m_axis_tready is high; input register -> step logic -> result reg
// the step logic (key map lookup, row*COLUMNS+column) is the only stage
// reset: rst_n low clears shift, caps, cursor and line length, attribute to 0x0F
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "keyboard_line_editor_text_console_unit_defines.svh"

module keyboard_line_editor_text_console_unit #(
    parameter int COLUMNS    = kle_pkg::COLUMNS_DEF,
    parameter int ROWS       = kle_pkg::ROWS_DEF,
    parameter int LINE_STORE = kle_pkg::LINE_STORE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // attribute register write
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [kle_pkg::ATTR_W-1:0]     cfg_data,      // text_attribute
    // scancode stream
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [kle_pkg::CODE_W-1:0]     s_axis_tdata,  // scancode
    // result stream
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // low to high: write_valid, write_attr_valid, write_address[11],
    // write_char[8], write_attr[8], cursor_changed, cursor_position[11],
    // line_submit, line_length[8], char_appended, zero fill
    output logic [kle_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import kle_pkg::*;

    localparam int COL_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LEN_W = (LINE_STORE > 1) ? $clog2(LINE_STORE) : 1;

    // input stage
    logic              in_valid_reg;
    logic [CODE_W-1:0] in_code_reg;

    // editor state
    logic [ATTR_W-1:0] attr_reg;
    logic              shift_reg,  shift_next;
    logic              caps_reg,   caps_next;
    logic [COL_W-1:0]  col_reg,    col_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [LEN_W-1:0]  len_reg,    len_next;

    // result stage
    logic              out_valid_reg;
    kle_result_t       out_data_reg;
    kle_result_t       step_result;

    logic              advance;

    // the input word moves on when the result register is free or drains now
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_data_reg};

    kle_step #(
        .COLUMNS    (COLUMNS),
        .ROWS       (ROWS),
        .LINE_STORE (LINE_STORE),
        .COL_W      (COL_W),
        .ROW_W      (ROW_W),
        .LEN_W      (LEN_W)
    ) u_step (
        .scancode           (in_code_reg),
        .text_attribute     (attr_reg),
        .shift_held         (shift_reg),
        .caps_active        (caps_reg),
        .cursor_column      (col_reg),
        .cursor_row         (row_reg),
        .typed_length       (len_reg),
        .shift_held_next    (shift_next),
        .caps_active_next   (caps_next),
        .cursor_column_next (col_next),
        .cursor_row_next    (row_next),
        .typed_length_next  (len_next),
        .result             (step_result)
    );

    // control and editor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            attr_reg      <= ATTR_RESET;
            shift_reg     <= 1'b0;
            caps_reg      <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            len_reg       <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
                attr_reg <= cfg_data;

            // state commits as the word enters the result register
            if (advance)
            begin
                shift_reg <= shift_next;
                caps_reg  <= caps_next;
                col_reg   <= col_next;
                row_reg   <= row_next;
                len_reg   <= len_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_code_reg <= s_axis_tdata;
        if (advance)
            out_data_reg <= step_result;
    end

    `KLE_ASSERT_IMP(a_row_in_range, 1'b1, row_reg <= ROW_W'(ROWS - 1), "cursor row past last row")
    `KLE_ASSERT_IMP(a_col_in_range, 1'b1, col_reg <= COL_W'(COLUMNS - 1), "cursor column past last column")
    `KLE_ASSERT_NXT(a_submit_clears, advance && step_result.line_submit, len_reg == '0, "line not cleared on submit")
    `KLE_ASSERT_NXT(a_stall_keeps_state, in_valid_reg && !advance, $stable(len_reg) && $stable(col_reg) && $stable(row_reg), "state moved while stalled")
    `KLE_ASSERT_IMP(a_attr_needs_write, out_valid_reg && out_data_reg.write_attr_valid, out_data_reg.write_valid, "attribute write without cell write")

endmodule
